// ===== hdl/sspa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspa_pkg
// Shared constants and controller/datapath command and status types for the
// swap slot bitmap allocator.
// ----------------------------------------------------------------------------
package sspa_pkg;

    localparam int NumSlotsDef       = 4096;
    localparam int SectorsPerSlotDef = 8;

    localparam int SectorW  = 15;
    localparam int WordW    = 64;
    localparam int BitW     = 6;
    localparam int SpsW     = 7;
    localparam int DivMulW  = 17;
    localparam int ProdW    = SectorW + DivMulW;

    localparam logic FuncAlloc = 1'b0;
    localparam logic FuncFree  = 1'b1;

    typedef struct packed {
        logic scan_start;
        logic scan_rd;
        logic hit_capture;
        logic fail;
        logic alloc_commit;
        logic free_load;
        logic free_rd;
        logic free_commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss_last;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/sspa_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspa_req_if
// Request channel: operation code and sector number, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sspa_req_if;

    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [sspa_pkg::SectorW-1:0] sector;

    modport source (output valid, output func, output sector, input ready);
    modport sink   (input valid, input func, input sector, output ready);

endinterface

// ===== hdl/sspa_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspa_rsp_if
// Response channel: allocated sector and success flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sspa_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [sspa_pkg::SectorW-1:0] alloc_sector;
    logic                         ok;

    modport source (output valid, output alloc_sector, output ok, input ready);
    modport sink   (input valid, input alloc_sector, input ok, output ready);

endinterface

// ===== hdl/sspa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspa_ctrl
// Sequencer for allocate scans and free read-modify-writes.
// ----------------------------------------------------------------------------
module sspa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    output logic              in_ready,
    input  sspa_pkg::status_t status,
    output sspa_pkg::cmd_t    cmd
);
    import sspa_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_AWR  = 6'b000100,
        S_FDIV = 6'b001000,
        S_FWR  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FuncFree)
                    begin
                        cmd.free_load = 1'b1;
                        state_next    = S_FDIV;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.hit)
                begin
                    cmd.hit_capture = 1'b1;
                    state_next      = S_AWR;
                end
                else if (status.miss_last)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_AWR:
            begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_DONE;
            end
            S_FDIV:
            begin
                cmd.free_rd = 1'b1;
                state_next  = S_FWR;
            end
            S_FWR:
            begin
                cmd.free_commit = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sspa_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspa_dpath
// Used-bit word memory, fill count, first-zero search, sector divide and
// multiply, and the response register.
// ----------------------------------------------------------------------------
module sspa_dpath #(
    parameter int NUM_SLOTS        = sspa_pkg::NumSlotsDef,
    parameter int SECTORS_PER_SLOT = sspa_pkg::SectorsPerSlotDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sspa_pkg::cmd_t               cmd,
    input  logic [sspa_pkg::SectorW-1:0] in_sector,
    input  logic                         out_ready,
    output sspa_pkg::status_t            status,
    output logic                         out_valid,
    output logic [sspa_pkg::SectorW-1:0] out_alloc_sector,
    output logic                         out_ok
);
    import sspa_pkg::*;

    localparam int Words    = (NUM_SLOTS + WordW - 1) / WordW;
    localparam int AddrW    = (Words > 1) ? $clog2(Words) : 1;
    localparam int IdxW     = AddrW + BitW;
    localparam int FillW    = $clog2(Words + 1);
    localparam int CmpW     = (FillW > AddrW) ? FillW : AddrW;
    localparam int DivShift = SectorW + $clog2(SECTORS_PER_SLOT);
    localparam longint DivMul =
        ((longint'(1) << DivShift) + SECTORS_PER_SLOT - 1) / SECTORS_PER_SLOT;

    localparam logic [DivMulW-1:0] DivMulC   = DivMulW'(DivMul);
    localparam logic [SpsW-1:0]    SpsC      = SpsW'(SECTORS_PER_SLOT);
    localparam logic [AddrW-1:0]   LastIdx   = AddrW'(Words - 1);
    localparam logic [IdxW:0]      NumSlotsC = (IdxW + 1)'(NUM_SLOTS);
    localparam logic [FillW-1:0]   WordsC    = FillW'(Words);

    logic [WordW-1:0]   mem [Words];
    logic [WordW-1:0]   rd_reg;
    logic               rdz_reg;
    logic               rdv_reg;
    logic [AddrW-1:0]   ptr_reg;
    logic [AddrW-1:0]   eidx_reg;
    logic [AddrW-1:0]   widx_reg;
    logic [BitW-1:0]    bit_reg;
    logic [WordW-1:0]   word_reg;
    logic [ProdW-1:0]   prod_reg;
    logic               frange_reg;
    logic [FillW-1:0]   fill_reg;
    logic [FillW-1:0]   fill_next;
    logic [SectorW-1:0] res_sector_reg;
    logic               res_ok_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SectorW-1:0] out_sector_reg;
    logic               out_ok_reg;

    logic [WordW-1:0]     rd_word;
    logic                 word_full;
    logic [BitW-1:0]      lz;
    logic [SectorW-1:0]   fquot;
    logic                 frange_c;
    logic [IdxW-1:0]      fslot;
    logic [IdxW-1:0]      aslot;
    logic                 aok;
    logic [IdxW+SpsW-1:0] aprod;
    logic [AddrW-1:0]     raddr;
    logic                 re;
    logic                 we;
    logic [WordW-1:0]     bit_mask;
    logic [WordW-1:0]     wdata;
    logic                 rdz_c;

    assign rd_word   = rdz_reg ? '0 : rd_reg;
    assign word_full = &rd_word;

    always_comb
    begin
        lz = '0;
        for (int i = WordW - 1; i >= 0; i--)
        begin
            if (!rd_word[i])
            begin
                lz = BitW'(i);
            end
        end
    end

    assign status.hit       = rdv_reg & ~word_full;
    assign status.miss_last = rdv_reg & word_full & (eidx_reg == LastIdx);
    assign status.out_free  = ~out_valid_reg | out_ready;

    assign fquot    = SectorW'(prod_reg >> DivShift);
    assign frange_c = (32'(fquot) < 32'(NUM_SLOTS));
    assign fslot    = IdxW'(fquot);

    assign aslot = {widx_reg, bit_reg};
    assign aok   = ({1'b0, aslot} < NumSlotsC);
    assign aprod = (IdxW + SpsW)'(aslot) * (IdxW + SpsW)'(SpsC);

    assign raddr = cmd.free_rd ? fslot[IdxW-1:BitW] : ptr_reg;
    assign re    = cmd.free_rd | cmd.scan_rd;
    assign rdz_c = (CmpW'(raddr) >= CmpW'(fill_reg));

    assign bit_mask = WordW'(1) << bit_reg;
    assign we       = (cmd.alloc_commit & aok) | (cmd.free_commit & frange_reg & ~rdz_reg);
    assign wdata    = cmd.alloc_commit ? (word_reg | bit_mask) : (rd_word & ~bit_mask);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[widx_reg] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_reg  <= mem[raddr];
            rdz_reg <= rdz_c;
        end
        if (cmd.scan_rd)
        begin
            eidx_reg <= ptr_reg;
        end
        if (cmd.hit_capture)
        begin
            widx_reg <= eidx_reg;
            bit_reg  <= lz;
            word_reg <= rd_word;
        end
        if (cmd.free_load)
        begin
            prod_reg <= ProdW'(in_sector) * ProdW'(DivMulC);
        end
        if (cmd.free_rd)
        begin
            widx_reg   <= fslot[IdxW-1:BitW];
            bit_reg    <= fslot[BitW-1:0];
            frange_reg <= frange_c;
        end
        if (cmd.fail)
        begin
            res_sector_reg <= '0;
            res_ok_reg     <= 1'b0;
        end
        if (cmd.alloc_commit)
        begin
            res_sector_reg <= aok ? SectorW'(aprod) : '0;
            res_ok_reg     <= aok;
        end
        if (cmd.free_commit)
        begin
            res_sector_reg <= '0;
            res_ok_reg     <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_sector_reg <= res_sector_reg;
            out_ok_reg     <= res_ok_reg;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.alloc_commit && aok && (CmpW'(widx_reg) == CmpW'(fill_reg)))
        begin
            fill_next = fill_reg + FillW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cmd.scan_start)
            begin
                ptr_reg <= '0;
                rdv_reg <= 1'b0;
            end
            else if (cmd.scan_rd)
            begin
                ptr_reg <= (ptr_reg == LastIdx) ? ptr_reg : ptr_reg + AddrW'(1);
                rdv_reg <= 1'b1;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_alloc_sector = out_sector_reg;
    assign out_ok           = out_ok_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= WordsC)
        else $error("fill count beyond word count");

    a_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CmpW'(widx_reg) <= CmpW'(fill_reg)))
        else $error("memory write above fill count");

    a_hit_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_rd && status.hit) |-> (CmpW'(eidx_reg) <= CmpW'(fill_reg)))
        else $error("scan passed the fill count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("response register overwritten");

    a_fail_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit && !aok) |=> $stable(fill_reg))
        else $error("fill count moved on failed allocate");

endmodule

// ===== hdl/swap_slot_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_top
// First-fit bitmap allocator: one used bit per swap slot, allocate returns
// the first sector of the lowest free slot, free clears a slot's bit.
//
//   channel  dir  fields                    transaction
//   req      in   func, sector              valid & ready
//   rsp      out  alloc_sector, ok          valid & ready
//
// Allocate: the scan reads one word a cycle from word 0 up to the first
// 64-bit word holding a free slot, then the slot's bit is written.
// Free: the divide's multiply is taken with the transaction, then read,
// write, response load.
// Reset clears control and the fill count; words above the fill count read
// as free, so no clearing pass runs.
// A new request is taken while the previous response waits on rsp.ready.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_top #(
    parameter int NUM_SLOTS        = sspa_pkg::NumSlotsDef,
    parameter int SECTORS_PER_SLOT = sspa_pkg::SectorsPerSlotDef
) (
    input logic        clk,
    input logic        rst_n,
    sspa_req_if.sink   req,
    sspa_rsp_if.source rsp
);
    import sspa_pkg::*;

    cmd_t    cmd;
    status_t status;

    sspa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req.func),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sspa_dpath #(
        .NUM_SLOTS        (NUM_SLOTS),
        .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .in_sector        (req.sector),
        .out_ready        (rsp.ready),
        .status           (status),
        .out_valid        (rsp.valid),
        .out_alloc_sector (rsp.alloc_sector),
        .out_ok           (rsp.ok)
    );

endmodule

// ===== test/swap_slot_bitmap_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_bitmap_allocator_top_tb
// Self-checking bench for the first-fit swap slot allocator. A short table of
// requests covers reset, the sector extremes, double and unaligned frees; a
// run of allocations then builds up the map, and random mixes of
// allocations and frees follow under changing back-pressure. Every response
// is checked against its table entry or a slot map kept alongside the block.
// ----------------------------------------------------------------------------
module swap_slot_bitmap_allocator_top_tb;

    import sspa_pkg::*;

    localparam int NumSlots       = NumSlotsDef;
    localparam int SectorsPerSlot = SectorsPerSlotDef;
    localparam int MapWords       = (NumSlots + 63) / 64;
    localparam int CycleLimit     = 3000000;
    localparam int TailCycles     = 80;
    localparam int LongStall      = 600;
    localparam int DirectedRows   = 17;
    localparam int FillRun        = 500;
    localparam int RandomRun      = 360;

    typedef struct packed {
        logic [SectorW-1:0] alloc_sector;
        logic               ok;
    } grant_t;

    typedef struct {
        logic               func;
        logic [SectorW-1:0] sector;
        bit                 typed;
        grant_t             want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    sspa_req_if req_if ();
    sspa_rsp_if rsp_if ();

    swap_slot_bitmap_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [63:0] slot_map [MapWords];
    grant_t      grant_q [$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int response_count = 0;
    int granted_count  = 0;
    int refused_count  = 0;
    int freed_count    = 0;
    int send_idle      = 37;
    int recv_idle      = 79;
    bit want_long_stall = 1'b0;

    directed_row_t directed_rows [DirectedRows] = '{
        '{FuncAlloc, 15'd0,     1'b1, '{15'd0,  1'b1}},
        '{FuncAlloc, 15'd32767, 1'b1, '{15'd8,  1'b1}},
        '{FuncAlloc, 15'd0,     1'b1, '{15'd16, 1'b1}},
        '{FuncFree,  15'd8,     1'b1, '{15'd0,  1'b1}},
        '{FuncAlloc, 15'd0,     1'b0, '{15'd0,  1'b0}},
        '{FuncFree,  15'd13,    1'b0, '{15'd0,  1'b0}},
        '{FuncFree,  15'd13,    1'b0, '{15'd0,  1'b0}},
        '{FuncFree,  15'd32767, 1'b1, '{15'd0,  1'b1}},
        '{FuncFree,  15'd0,     1'b1, '{15'd0,  1'b1}},
        '{FuncAlloc, 15'd0,     1'b0, '{15'd0,  1'b0}},
        '{FuncAlloc, 15'd0,     1'b0, '{15'd0,  1'b0}},
        '{FuncAlloc, 15'd21845, 1'b0, '{15'd0,  1'b0}},
        '{FuncFree,  15'd16,    1'b0, '{15'd0,  1'b0}},
        '{FuncFree,  15'd23,    1'b0, '{15'd0,  1'b0}},
        '{FuncAlloc, 15'd10922, 1'b0, '{15'd0,  1'b0}},
        '{FuncFree,  15'd32760, 1'b1, '{15'd0,  1'b1}},
        '{FuncAlloc, 15'd0,     1'b0, '{15'd0,  1'b0}}
    };

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic grant_t predict_grant(input logic func,
                                             input logic [SectorW-1:0] sector);
        grant_t      g;
        int unsigned w;
        int unsigned b;
        int unsigned slot;
        g.alloc_sector = '0;
        g.ok           = 1'b1;
        if (func == FuncAlloc) begin
            g.ok = 1'b0;
            for (w = 0; w < MapWords; w++) begin
                if (slot_map[w] != {64{1'b1}}) begin
                    b = 0;
                    while (b < 63 && slot_map[w][b])
                        b++;
                    slot = w * 64 + b;
                    if (slot < NumSlots) begin
                        slot_map[w][b] = 1'b1;
                        g.alloc_sector = SectorW'(slot * SectorsPerSlot);
                        g.ok           = 1'b1;
                    end
                    break;
                end
            end
        end
        else begin
            slot = sector / SectorsPerSlot;
            if (slot < NumSlots)
                slot_map[slot / 64][slot % 64] = 1'b0;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s, got %0d, want %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic issue_request(input logic func, input logic [SectorW-1:0] sector,
                                 input bit typed, input grant_t typed_grant);
        grant_t g;
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.func   <= func;
        req_if.sector <= sector;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        g = predict_grant(func, sector);
        grant_q.push_back(typed ? typed_grant : g);
        if (func == FuncFree)
            freed_count++;
        else if (g.ok)
            granted_count++;
        else
            refused_count++;
    endtask

    task automatic issue_random(input int count, input int alloc_pct);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < alloc_pct)
                issue_request(FuncAlloc, SectorW'($urandom), 1'b0, '0);
            else if (roll < alloc_pct + 20)
                issue_request(FuncFree,
                              SectorW'($urandom_range(NumSlots - 1) * SectorsPerSlot),
                              1'b0, '0);
            else
                issue_request(FuncFree, SectorW'($urandom_range(32767)), 1'b0, '0);
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int stall_left;
        bit stall_taken;
        stall_left   = 0;
        stall_taken  = 1'b0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (want_long_stall && !stall_taken) begin
                stall_taken = 1'b1;
                stall_left  = LongStall;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk) begin
        grant_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            response_count++;
            if (grant_q.size() == 0) begin
                report_mismatch("response with no transaction outstanding",
                                int'(rsp_if.alloc_sector), 0);
            end
            else begin
                want = grant_q.pop_front();
                if (rsp_if.alloc_sector !== want.alloc_sector)
                    report_mismatch("alloc_sector", int'(rsp_if.alloc_sector),
                                    int'(want.alloc_sector));
                if (rsp_if.ok !== want.ok)
                    report_mismatch("ok", int'(rsp_if.ok), int'(want.ok));
            end
        end
    end

    initial begin
        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FuncAlloc;
        req_if.sector = '0;
        for (int w = 0; w < MapWords; w++)
            slot_map[w] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            issue_request(directed_rows[r].func, directed_rows[r].sector,
                          directed_rows[r].typed, directed_rows[r].want);

        repeat (FillRun)
            issue_request(FuncAlloc, SectorW'($urandom), 1'b0, '0);

        issue_random(RandomRun, 40);

        send_idle = 79;
        recv_idle = 37;
        issue_random(RandomRun, 50);

        send_idle       = 0;
        recv_idle       = 0;
        want_long_stall = 1'b1;
        issue_random(RandomRun, 70);

        req_if.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("Checked %0d responses: %0d slots granted, %0d refused,",
                 response_count, granted_count, refused_count);
        $display("%0d frees, over %0d cycles of mixed back-pressure.",
                 freed_count, cycle_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
